// ===== rtl/core/ftq_pkg.sv =====
// Shared constants, codes and helpers for the framed transmit queue.
`default_nettype none

package ftq_pkg;

    localparam logic OP_PUT   = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [7:0] MARK_OPEN  = 8'h3E;
    localparam logic [7:0] MARK_CLOSE = 8'h3C;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_A    = 8'h41;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;

    localparam int TDATA_W = 24;
    localparam int TUSER_W = 2;

    // Upper-case hex digit of a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] digit;
        if (nib <= DIGIT_MAX) begin
            digit = ASCII_ZERO + {4'd0, nib};
        end else begin
            digit = ASCII_A + {4'd0, nib} - 8'd10;
        end
        return digit;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ftq_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module ftq_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire logic [DATA_W-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic      [DATA_W-1:0]         rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/framed_tx_queue_xor_checksum.sv =====
// Framed transmit queue: ring buffer with XOR checksum framing, top level.
//
// Input channel s_*: s_tuser is the op (0 = put s_tdata[7:0], 1 = drain).
// Result channel m_*: one result item per input item, in order.
// A put queues the character; '>' clears the running XOR checksum, '<' is
// queued followed by two upper-case hex digits of the checksum, and any other
// character is XORed into it. A put that lacks room (3 entries for '<',
// 1 otherwise) is refused whole and reports status 1. A drain pops the oldest
// byte if one is queued. Each result carries free space and a pending flag.
// Timing: one item in flight. A plain or refused put and an empty drain go
// from acceptance to the done state and then to the result register; a
// popping drain first passes the RAM read state, a '<' put the two hex-digit
// states (one queue write per cycle through the single RAM write port).
// s_tready is high only while the controller is idle; the result register
// lets the next item be accepted while a result still waits on m_tready.
// When the receiver stalls, the finished item holds in the done state until
// the result register drains.
// Reset (aresetn low, synchronous) empties the queue and clears the checksum;
// the RAM contents are not cleared and need no clearing pass.
`default_nettype none

module framed_tx_queue_xor_checksum #(
    parameter int QUEUE_DEPTH = 256
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] char_in
    input  wire logic                            s_tuser,   // [0] op
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] tx_byte, [15:8] free_space, [16] pending, [23:17] zero
    output logic [ftq_pkg::TDATA_W-1:0]          m_tdata,
    // [0] tx_valid, [1] status
    output logic [ftq_pkg::TUSER_W-1:0]          m_tuser
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W+1)'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEX_HI,
        ST_HEX_LO,
        ST_READ,
        ST_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [7:0] cs_reg, cs_next;
    logic [7:0] byte_reg, byte_next;
    logic       txv_reg, txv_next;
    logic       status_reg, status_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [ftq_pkg::TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [ftq_pkg::TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic             ram_we;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;
    logic [PTR_W:0]   diff;
    logic [PTR_W-1:0] used;
    logic [PTR_W-1:0] free_cnt;
    logic             accept;
    logic             out_free;
    logic             need_three;
    logic             room_ok;

    ftq_ram #(
        .DATA_W (8),
        .DEPTH  (QUEUE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (ram_wdata),
        .rd_addr (rp_reg),
        .rd_data (ram_rdata)
    );

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        diff = {1'b0, wp_reg} - {1'b0, rp_reg};
        if (wp_reg < rp_reg) begin
            diff = diff + DEPTH_EXT;
        end
        used     = diff[PTR_W-1:0];
        free_cnt = LAST_IDX - used;
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign need_three = (s_tdata == ftq_pkg::MARK_CLOSE);
    assign room_ok    = need_three ? (free_cnt >= PTR_W'(3)) : (free_cnt != '0);

    always_comb begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        cs_next       = cs_reg;
        byte_next     = byte_reg;
        txv_next      = txv_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        ram_wdata     = s_tdata;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    byte_next   = '0;
                    txv_next    = 1'b0;
                    status_next = 1'b0;
                    state_next  = ST_DONE;
                    if (s_tuser == ftq_pkg::OP_DRAIN) begin
                        if (used != '0) begin
                            state_next = ST_READ;
                        end
                    end else if (!room_ok) begin
                        status_next = 1'b1;
                    end else begin
                        ram_we  = 1'b1;
                        wp_next = advance(wp_reg);
                        if (s_tdata == ftq_pkg::MARK_OPEN) begin
                            cs_next = '0;
                        end else if (need_three) begin
                            state_next = ST_HEX_HI;
                        end else begin
                            cs_next = cs_reg ^ s_tdata;
                        end
                    end
                end
            end
            ST_HEX_HI: begin
                ram_we     = 1'b1;
                ram_wdata  = ftq_pkg::hex_digit(cs_reg[7:4]);
                wp_next    = advance(wp_reg);
                state_next = ST_HEX_LO;
            end
            ST_HEX_LO: begin
                ram_we     = 1'b1;
                ram_wdata  = ftq_pkg::hex_digit(cs_reg[3:0]);
                wp_next    = advance(wp_reg);
                state_next = ST_DONE;
            end
            ST_READ: begin
                byte_next  = ram_rdata;
                txv_next   = 1'b1;
                rp_next    = advance(rp_reg);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, (used != '0), 8'(free_cnt), byte_reg};
                    m_tuser_next  = {status_reg, txv_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            rp_reg       <= '0;
            cs_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            cs_reg       <= cs_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        byte_reg    <= byte_next;
        txv_reg     <= txv_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A popped byte and a refused put never appear in one result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result flags both popped and refused");

    // An empty queue reports full free space.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[16]) |-> (m_tdata[15:8] == 8'(LAST_IDX)))
        else $error("empty queue with wrong free space");

    // A refused put only happens when fewer than three entries are free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[15:8] < 8'd3))
        else $error("put refused with room available");

    // Queue writes never happen while a drain is reading or a finished item holds in the done state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_READ) || (state_reg == ST_DONE)) |-> !ram_we)
        else $error("queue write outside put sequence");

    // Pointers stay inside the ring.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wp_reg <= LAST_IDX) && (rp_reg <= LAST_IDX))
        else $error("queue pointer out of range");

endmodule

`default_nettype wire
